@@ sv/dual_path_fetch_mode_switcher_macros.svh @@
// assertion macros for the dual-path fetch mode switcher
// relies on clk and arst_n being visible in the module that expands them
`ifndef DUAL_PATH_FETCH_MODE_SWITCHER_MACROS_SVH
`define DUAL_PATH_FETCH_MODE_SWITCHER_MACROS_SVH
`ifndef SYNTH
// condition holds at every edge out of reset
`define DPFS_CHECK(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dpfs check failed");
// same-cycle implication
`define DPFS_CHECK_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpfs implication failed");
// next-cycle implication
`define DPFS_CHECK_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpfs next-cycle check failed");
`else
`define DPFS_CHECK(label, expr)
`define DPFS_CHECK_IMP(label, ante, cons)
`define DPFS_CHECK_NXT(label, ante, cons)
`endif
`endif

@@ sv/dpfs_pkg.sv @@
// shared types and constants of the dual-path fetch mode switcher
// no dependencies
`default_nettype none
package dpfs_pkg;

	// field widths fixed by the interface
	localparam int WSIZE_W   = 9;
	localparam int PCT_W     = 7;
	localparam int CONF_W    = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 9;
	localparam int OUT_CNT_W = 32;
	localparam int CONF_PROD_W = 18;

	// arithmetic constants
	localparam logic [CONF_W-1:0] CONF_ONE  = 11'd1024;
	localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;
	localparam int                SPIKE_RUN = 5;

	// item kinds
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// switch event codes
	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_TO_SINGLE = 2'd1;
	localparam logic [1:0] EV_TO_DUAL   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONF_PCT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_METRIC      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DUAL   = 3'd6;

	// register reset values
	localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 9'd100;
	localparam logic [PCT_W-1:0]   HIGH_PCT_RST    = 7'd90;
	localparam logic [PCT_W-1:0]   LOW_PCT_RST     = 7'd80;
	localparam logic [PCT_W-1:0]   CONF_PCT_RST    = 7'd50;
	localparam logic               METRIC_RST      = 1'b0;
	localparam logic               POLICY_RST      = 1'b0;
	localparam logic               INIT_DUAL_RST   = 1'b0;

	// push request from the control logic into the outcome window
	typedef struct packed {
		logic push;
		logic outcome;
	} win_ctl_t;

endpackage
`default_nettype wire

@@ sv/dual_path_fetch_mode_switcher.sv @@
// channel    | direction | handshake               | payload
// item       | in        | item_valid / item_stall | mode, correct, confidence
// result     | out       | result_valid / result_stall | dual_mode .. max_conf_seen
// cfg        | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one item per cycle while item_stall is low, result is registered and appears the cycle after the beat
// the update path runs window tap select, hit count, multiplies and compares
// into the mode flag, all within that cycle
// item_stall follows result_stall while a result is held; cfg_ready is always high
// asynchronous reset clears counters, loads register defaults, mode flag = INIT_DUAL_RST
// depends on dpfs_pkg, dpfs_window, dpfs_cell and the assertion macro header
`default_nettype none
`include "dual_path_fetch_mode_switcher_macros.svh"
module dual_path_fetch_mode_switcher import dpfs_pkg::*; #(
	parameter int WINDOW_MAX  = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item channel
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic                 mode,
	input  wire logic                 correct,
	input  wire logic [CONF_W-1:0]    confidence,
	// result channel
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      dual_mode,
	output logic                      fetch_alternate,
	output logic [1:0]                switch_event,
	output logic [8:0]                correct_in_window,
	output logic [8:0]                window_fill,
	output logic [OUT_CNT_W-1:0]      miss_run,
	output logic [OUT_CNT_W-1:0]      max_miss_run_single,
	output logic [OUT_CNT_W-1:0]      spike_count,
	output logic [OUT_CNT_W-1:0]      to_single_count,
	output logic [OUT_CNT_W-1:0]      to_dual_count,
	output logic [CONF_W-1:0]         min_conf_seen,
	output logic [CONF_W-1:0]         max_conf_seen,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int EW     = (FILL_W > WSIZE_W) ? FILL_W : WSIZE_W;
	localparam int PW     = FILL_W + PCT_W;
	localparam int CP     = CONF_PROD_W;

	// configuration registers
	logic [WSIZE_W-1:0] window_size_q;
	logic [PCT_W-1:0]   high_pct_q;
	logic [PCT_W-1:0]   low_pct_q;
	logic [PCT_W-1:0]   conf_pct_q;
	logic               metric_q;
	logic               policy_q;

	// block state
	logic                   dual_q;
	logic [COUNT_WIDTH-1:0] run_q, worst_q, spikes_q, to_single_q, to_dual_q;
	logic [CONF_W-1:0]      conf_low_q, conf_high_q;

	// next state
	logic                   dual_nx;
	logic [COUNT_WIDTH-1:0] run_nx, worst_nx, spikes_nx, to_single_nx, to_dual_nx;
	logic [CONF_W-1:0]      conf_low_nx, conf_high_nx;
	logic [1:0]             event_nx;
	logic                   fetch_nx;

	// result register
	logic       result_valid_q;
	logic [1:0] event_s1;
	logic       fetch_s1;

	logic              accept, is_update, cfg_wr;
	logic [CONF_W-1:0] conf_sat;
	logic [CP-1:0]     conf_prod;
	logic              conf_lt_fetch, conf_ge_high, conf_lt_low;
	logic [EW-1:0]     ws_ext, eff_ext;
	logic [FILL_W-1:0] eff_win;
	logic [FILL_W-1:0] fill_q, hit_q, fill_nx, hit_nx;
	logic [PW-1:0]     acc_prod, high_prod, low_prod;
	logic              decide, at_high, below_low;
	win_ctl_t          win_ctl;

	// handshakes
	assign accept     = item_valid && !item_stall;
	assign is_update  = accept && (mode == MODE_UPDATE);
	assign item_stall = result_valid_q && result_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;

	// clamp window size to 1 .. WINDOW_MAX
	assign ws_ext  = EW'(window_size_q);
	assign eff_ext = (ws_ext == '0) ? EW'(1) :
		(ws_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : ws_ext;
	assign eff_win = FILL_W'(eff_ext);

	// outcome window
	assign win_ctl.push    = is_update;
	assign win_ctl.outcome = correct;

	dpfs_window #(
		.WINDOW_MAX (WINDOW_MAX),
		.FILL_W     (FILL_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.eff_win (eff_win),
		.fill_q  (fill_q),
		.hit_q   (hit_q),
		.fill_nx (fill_nx),
		.hit_nx  (hit_nx)
	);

	// confidence percent compares, exact cross products
	assign conf_sat      = (confidence > CONF_ONE) ? CONF_ONE : confidence;
	assign conf_prod     = CP'(conf_sat) * CP'(PCT_SCALE);
	assign conf_lt_fetch = conf_prod < (CP'(conf_pct_q) * CP'(CONF_ONE));
	assign conf_ge_high  = conf_prod >= (CP'(high_pct_q) * CP'(CONF_ONE));
	assign conf_lt_low   = conf_prod < (CP'(low_pct_q) * CP'(CONF_ONE));

	// windowed accuracy compares on the counters after this push
	assign acc_prod  = PW'(hit_nx) * PW'(PCT_SCALE);
	assign high_prod = PW'(high_pct_q) * PW'(fill_nx);
	assign low_prod  = PW'(low_pct_q) * PW'(fill_nx);

	// switching metric select
	always_comb begin
		if (metric_q) begin
			decide    = 1'b1;
			at_high   = conf_ge_high;
			below_low = conf_lt_low;
		end else begin
			decide    = fill_nx >= eff_win;
			at_high   = acc_prod >= high_prod;
			below_low = acc_prod < low_prod;
		end
	end

	// update step: miss runs, marks, mode switch
	always_comb begin
		dual_nx      = dual_q;
		run_nx       = run_q;
		worst_nx     = worst_q;
		spikes_nx    = spikes_q;
		to_single_nx = to_single_q;
		to_dual_nx   = to_dual_q;
		conf_low_nx  = conf_low_q;
		conf_high_nx = conf_high_q;
		event_nx     = EV_NONE;
		if (is_update) begin
			if (correct) begin
				run_nx = '0;
			end else begin
				run_nx = (run_q == '1) ? run_q : run_q + COUNT_WIDTH'(1);
				if (!dual_q) begin
					if (run_nx > worst_q) begin
						worst_nx = run_nx;
					end
					if (run_nx == COUNT_WIDTH'(SPIKE_RUN)) begin
						spikes_nx = (spikes_q == '1) ? spikes_q : spikes_q + COUNT_WIDTH'(1);
					end
				end
			end
			if (conf_sat < conf_low_q) begin
				conf_low_nx = conf_sat;
			end
			if (conf_sat > conf_high_q) begin
				conf_high_nx = conf_sat;
			end
			if (decide) begin
				if (dual_q && at_high) begin
					dual_nx      = 1'b0;
					to_single_nx = (to_single_q == '1) ? to_single_q :
						to_single_q + COUNT_WIDTH'(1);
					event_nx     = EV_TO_SINGLE;
				end else if (!dual_q && below_low) begin
					dual_nx    = 1'b1;
					to_dual_nx = (to_dual_q == '1) ? to_dual_q : to_dual_q + COUNT_WIDTH'(1);
					event_nx   = EV_TO_DUAL;
				end
			end
		end
	end

	// fetch rule: the flag after the item gates it unless policy is set
	assign fetch_nx = policy_q ? conf_lt_fetch : (dual_nx && conf_lt_fetch);

	// configuration registers; initial_dual only presets the mode flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			high_pct_q    <= HIGH_PCT_RST;
			low_pct_q     <= LOW_PCT_RST;
			conf_pct_q    <= CONF_PCT_RST;
			metric_q      <= METRIC_RST;
			policy_q      <= POLICY_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_WINDOW_SIZE: window_size_q <= cfg_data[WSIZE_W-1:0];
				CFG_HIGH_PCT:    high_pct_q    <= cfg_data[PCT_W-1:0];
				CFG_LOW_PCT:     low_pct_q     <= cfg_data[PCT_W-1:0];
				CFG_CONF_PCT:    conf_pct_q    <= cfg_data[PCT_W-1:0];
				CFG_METRIC:      metric_q      <= cfg_data[0];
				CFG_POLICY:      policy_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// statistics and mode flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_q      <= INIT_DUAL_RST;
			run_q       <= '0;
			worst_q     <= '0;
			spikes_q    <= '0;
			to_single_q <= '0;
			to_dual_q   <= '0;
			conf_low_q  <= CONF_ONE;
			conf_high_q <= '0;
		end else begin
			if (cfg_wr && (cfg_index == CFG_INIT_DUAL)) begin
				dual_q <= cfg_data[0];
			end else begin
				dual_q <= dual_nx;
			end
			run_q       <= run_nx;
			worst_q     <= worst_nx;
			spikes_q    <= spikes_nx;
			to_single_q <= to_single_nx;
			to_dual_q   <= to_dual_nx;
			conf_low_q  <= conf_low_nx;
			conf_high_q <= conf_high_nx;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// per-item result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			event_s1 <= event_nx;
			fetch_s1 <= fetch_nx;
		end
	end

	// fields hold until a beat is accepted; an initial_dual write also sets dual_mode
	assign result_valid        = result_valid_q;
	assign dual_mode           = dual_q;
	assign fetch_alternate     = fetch_s1;
	assign switch_event        = event_s1;
	assign correct_in_window   = 9'(hit_q);
	assign window_fill         = 9'(fill_q);
	assign miss_run            = OUT_CNT_W'(run_q);
	assign max_miss_run_single = OUT_CNT_W'(worst_q);
	assign spike_count         = OUT_CNT_W'(spikes_q);
	assign to_single_count     = OUT_CNT_W'(to_single_q);
	assign to_dual_count       = OUT_CNT_W'(to_dual_q);
	assign min_conf_seen       = conf_low_q;
	assign max_conf_seen       = conf_high_q;

	`DPFS_CHECK_IMP(a_single_event_flag, result_valid_q && (event_s1 == EV_TO_SINGLE), !dual_q)
	`DPFS_CHECK_IMP(a_dual_event_flag, result_valid_q && (event_s1 == EV_TO_DUAL), dual_q)
	`DPFS_CHECK_NXT(a_query_no_switch, accept && (mode == MODE_QUERY), event_s1 == EV_NONE)
	`DPFS_CHECK_NXT(a_query_keeps_run, accept && (mode == MODE_QUERY), run_q == $past(run_q))

endmodule
`default_nettype wire

@@ sv/dpfs_cell.sv @@
// one position of the outcome window shift chain
// standalone, no package needed
`default_nettype none
module dpfs_cell #(
	parameter int IDX    = 0,
	parameter int FILL_W = 9
) (
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire logic              bit_in,
	input  wire logic [FILL_W-1:0] fill,
	output logic                   bit_out,
	output logic                   tap
);

	logic outcome_q;

	// take bit_in (the neighbor's outcome, or the new outcome at cell 0) on every push
	always_ff @(posedge clk) begin
		if (shift) begin
			outcome_q <= bit_in;
		end
	end

	// this cell holds the oldest outcome when it sits at fill - 1
	assign bit_out = outcome_q;
	assign tap     = outcome_q & (fill == FILL_W'(IDX + 1));

endmodule
`default_nettype wire

@@ sv/dpfs_window.sv @@
// sliding outcome window: chain of dpfs_cell plus fill and hit counters
// depends on dpfs_pkg, dpfs_cell and the assertion macro header
`default_nettype none
`include "dual_path_fetch_mode_switcher_macros.svh"
module dpfs_window import dpfs_pkg::*; #(
	parameter int WINDOW_MAX = 256,
	parameter int FILL_W     = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire win_ctl_t          ctl,
	input  wire logic [FILL_W-1:0] eff_win,
	output logic [FILL_W-1:0]      fill_q,
	output logic [FILL_W-1:0]      hit_q,
	output logic [FILL_W-1:0]      fill_nx,
	output logic [FILL_W-1:0]      hit_nx
);

	logic [WINDOW_MAX-1:0] chain;
	logic [WINDOW_MAX-1:0] taps;
	logic                  drop;
	logic                  old_bit;

	// newest outcome enters cell 0, each cell passes to the next on a push
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic bit_in;
		if (i == 0) begin : g_head
			assign bit_in = ctl.outcome;
		end else begin : g_body
			assign bit_in = chain[i-1];
		end
		dpfs_cell #(
			.IDX    (i),
			.FILL_W (FILL_W)
		) u_cell (
			.clk     (clk),
			.shift   (ctl.push),
			.bit_in  (bit_in),
			.fill    (fill_q),
			.bit_out (chain[i]),
			.tap     (taps[i])
		);
	end

	// oldest outcome leaves once the window is at or past its size
	assign drop    = ctl.push && (fill_q >= eff_win) && (fill_q != '0);
	assign old_bit = |taps;

	// counters after this push
	always_comb begin
		fill_nx = fill_q;
		hit_nx  = hit_q;
		if (ctl.push) begin
			if (!drop) begin
				fill_nx = fill_q + FILL_W'(1);
			end
			if (drop && old_bit && (hit_q != '0)) begin
				hit_nx = hit_q - FILL_W'(1) + FILL_W'(ctl.outcome);
			end else begin
				hit_nx = hit_q + FILL_W'(ctl.outcome);
			end
		end
	end

	// window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q  <= '0;
		end else begin
			fill_q <= fill_nx;
			hit_q  <= hit_nx;
		end
	end

	`DPFS_CHECK(a_hit_within_fill, hit_q <= fill_q)
	`DPFS_CHECK(a_fill_bounded, fill_q <= FILL_W'(WINDOW_MAX))
	`DPFS_CHECK_NXT(a_fill_grows, ctl.push && !drop, fill_q == $past(fill_q) + FILL_W'(1))

endmodule
`default_nettype wire
